// ===== sv/pcx_rle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_pkg
// Shared types, constants and helpers of the PCX run-length line encoder.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

  localparam int unsigned  LEN_W      = 6;
  localparam int unsigned  SLOTS      = 4;
  localparam logic [7:0]   CODE_MARK  = 8'hC0;

  // One accepted item as seen by the back end: up to four code bytes,
  // packed from slot 0, and the slot that holds the final byte.
  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    logic [1:0]            last_slot;
  } job_t;

  // A run needs a count byte unless it is a single byte below the mark.
  function automatic logic needs_count(input logic [7:0] value, input logic [LEN_W-1:0] len);
    needs_count = (len > LEN_W'(1)) || (value >= CODE_MARK);
  endfunction

  function automatic logic [7:0] count_byte(input logic [LEN_W-1:0] len);
    count_byte = CODE_MARK | {2'b00, len};
  endfunction

endpackage
`default_nettype wire

// ===== sv/pcx_rle_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_if
// Valid/ready channels of the encoder: pixel input and code byte output.
// ----------------------------------------------------------------------------
interface pcx_rle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_a;
  logic [7:0] pixel_b;
  logic       line_end;

  modport source (output valid, output pixel_a, output pixel_b, output line_end,
                  input ready);
  modport sink   (input valid, input pixel_a, input pixel_b, input line_end,
                  output ready);
endinterface

interface pcx_rle_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_of_item;

  modport source (output valid, output code_byte, output last_of_item, input ready);
  modport sink   (input valid, input code_byte, input last_of_item, output ready);
endinterface
`default_nettype wire

// ===== sv/pcx_rle_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_front
// Accepts pixels, tracks the open run and packs the code bytes of each item.
// ----------------------------------------------------------------------------
module pcx_rle_front #(
  parameter int unsigned MAX_RUN = 63
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_wdata,
  pcx_rle_pix_if.sink          pixels,
  input  wire logic            queue_full,
  output logic                 push,
  output pcx_rle_pkg::job_t    job
);

  localparam logic [pcx_rle_pkg::LEN_W-1:0] MAX_LEN = pcx_rle_pkg::LEN_W'(MAX_RUN);

  logic                            blend_mode;
  logic [7:0]                      run_value;
  logic [pcx_rle_pkg::LEN_W-1:0]   run_length;
  logic                            run_open;

  logic [7:0]                      run_value_next;
  logic [pcx_rle_pkg::LEN_W-1:0]   run_length_next;
  logic                            run_open_next;

  logic [8:0]                      pix_sum;
  logic [7:0]                      pix;
  logic                            extend;
  logic                            close_old;
  logic [7:0]                      new_value;
  logic [pcx_rle_pkg::LEN_W-1:0]   new_length;
  logic [2:0]                      fill;
  logic                            accept;

  assign pixels.ready = !queue_full;
  assign accept       = pixels.valid && !queue_full;

  assign pix_sum = {1'b0, pixels.pixel_a} + {1'b0, pixels.pixel_b};
  assign pix     = blend_mode ? pix_sum[8:1] : pixels.pixel_a;

  assign extend     = run_open && (pix == run_value) && (run_length < MAX_LEN);
  assign close_old  = run_open && !extend;
  assign new_value  = extend ? run_value : pix;
  assign new_length = extend ? run_length + pcx_rle_pkg::LEN_W'(1) : pcx_rle_pkg::LEN_W'(1);

  always_comb begin
    fill      = 3'd0;
    job.bytes = '0;
    if (close_old) begin
      if (pcx_rle_pkg::needs_count(run_value, run_length)) begin
        job.bytes[fill[1:0]] = pcx_rle_pkg::count_byte(run_length);
        fill = fill + 3'd1;
      end
      job.bytes[fill[1:0]] = run_value;
      fill = fill + 3'd1;
    end
    if (pixels.line_end) begin
      if (pcx_rle_pkg::needs_count(new_value, new_length)) begin
        job.bytes[fill[1:0]] = pcx_rle_pkg::count_byte(new_length);
        fill = fill + 3'd1;
      end
      job.bytes[fill[1:0]] = new_value;
      fill = fill + 3'd1;
    end
    job.last_slot = 2'(fill - 3'd1);

    // Line end flushes the run; its value stays as is.
    run_value_next  = new_value;
    run_length_next = pixels.line_end ? '0 : new_length;
    run_open_next   = !pixels.line_end;
  end

  assign push = accept && (fill != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= 1'b0;
      run_value  <= '0;
      run_length <= '0;
      run_open   <= 1'b0;
    end else begin
      if (cfg_we) begin
        blend_mode <= cfg_wdata;
      end
      if (accept) begin
        run_value  <= run_value_next;
        run_length <= run_length_next;
        run_open   <= run_open_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/pcx_rle_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_queue
// Small FIFO of packed items between the front and the back end.
// ----------------------------------------------------------------------------
module pcx_rle_queue #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  not_empty,
  output logic                  full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign rdata     = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/pcx_rle_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_back
// Walks the bytes of the item at the queue head into the output register.
// ----------------------------------------------------------------------------
module pcx_rle_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pcx_rle_pkg::job_t head,
  input  wire logic              head_valid,
  output logic                   pop,
  pcx_rle_code_if.source         codes
);

  logic [1:0] slot;
  logic       out_valid;
  logic [7:0] code_byte;
  logic       last_of_item;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!out_valid || codes.ready);
  assign at_last = (slot == head.last_slot);
  assign pop     = load && at_last;

  assign codes.valid        = out_valid;
  assign codes.code_byte    = code_byte;
  assign codes.last_of_item = last_of_item;

  always_ff @(posedge clk) begin
    if (load) begin
      code_byte    <= head.bytes[slot];
      last_of_item <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= at_last ? 2'd0 : slot + 2'd1;
      end else if (codes.ready) begin
        // drop the byte once its transfer completes
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/pcx_rle_line_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_line_encoder
// PCX run-length encoder for a stream of pixel bytes, one scan line at a time.
// ----------------------------------------------------------------------------
// Usage:
//   pixels: one pixel per transfer (pixel_a, pixel_b, line_end). With
//     blend_mode set the encoded byte is (pixel_a + pixel_b) >> 1.
//   codes: one code byte per transfer; last_of_item marks the final byte
//     that a pixel caused. A pixel that only extends a run gives no byte.
//   cfg_we / cfg_wdata: write blend_mode while the encoder is idle.
// Timing:
//   A pixel is taken every cycle while the item queue has room. Its code
//   bytes pass through the item queue and then the output register, which
//   drives one byte per cycle while codes is ready. A pixel can yield up
//   to four bytes at a line end, so a stream where each pixel yields two
//   bytes or more fills the queue and is then held back by pixels.ready.
//   When codes stalls, the output register holds its byte and the queue
//   (QUEUE_DEPTH items) fills before pixels.ready drops.
// Reset: no run open, blend_mode cleared, queue empty, no output byte.
// ----------------------------------------------------------------------------
module pcx_rle_line_encoder #(
  parameter int unsigned MAX_RUN     = 63,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  pcx_rle_pix_if.sink      pixels,
  pcx_rle_code_if.source   codes
);

  localparam int unsigned JOB_W = $bits(pcx_rle_pkg::job_t);

  pcx_rle_pkg::job_t  job_in;
  pcx_rle_pkg::job_t  job_head;
  logic [JOB_W-1:0]   head_bits;
  logic               push;
  logic               pop;
  logic               head_valid;
  logic               queue_full;

  pcx_rle_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pixels     (pixels),
    .queue_full (queue_full),
    .push       (push),
    .job        (job_in)
  );

  pcx_rle_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (job_in),
    .pop       (pop),
    .rdata     (head_bits),
    .not_empty (head_valid),
    .full      (queue_full)
  );

  assign job_head = pcx_rle_pkg::job_t'(head_bits);

  pcx_rle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (job_head),
    .head_valid (head_valid),
    .pop        (pop),
    .codes      (codes)
  );

endmodule
`default_nettype wire

// ===== tb/pcx_rle_code_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_code_checker
// Watches the pixel, code and config ports of the encoder. It keeps its own
// run state and predicts the PCX code bytes that each pixel transfer must
// produce. Each code transfer is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------
module pcx_rle_code_checker #(
  parameter int unsigned MAX_RUN = 63
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  input  wire logic drained,
  pcx_rle_pix_if    pixels,
  pcx_rle_code_if   codes,
  output int        mismatch_count,
  output int        pending_codes,
  output int        pixel_count,
  output int        code_count
);

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_item;
  } code_rec_t;

  code_rec_t                     expected_codes[$];
  code_rec_t                     oldest;
  logic [7:0]                    run_val;
  logic [pcx_rle_pkg::LEN_W-1:0] run_len;
  logic                          run_on;
  logic                          blend_on;
  logic                          leftover_checked;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] code byte %0d: %s", $realtime, code_count, what);
  endtask

  // Flush the open run: count byte unless it is a lone byte below the mark.
  function automatic void close_run();
    if (run_len > pcx_rle_pkg::LEN_W'(1) || run_val >= pcx_rle_pkg::CODE_MARK)
      expected_codes.push_back('{code_byte: pcx_rle_pkg::CODE_MARK | {2'b00, run_len},
                                 last_of_item: 1'b0});
    expected_codes.push_back('{code_byte: run_val, last_of_item: 1'b0});
    run_on  = 1'b0;
    run_len = '0;
  endfunction

  task automatic predict_codes(input logic [7:0] a, input logic [7:0] b, input logic le);
    logic [8:0] pix_sum;
    logic [7:0] v;
    int         first;
    first   = expected_codes.size();
    pix_sum = {1'b0, a} + {1'b0, b};
    v       = blend_on ? pix_sum[8:1] : a;
    if (run_on && v == run_val && run_len < pcx_rle_pkg::LEN_W'(MAX_RUN)) begin
      run_len++;
    end else begin
      if (run_on)
        close_run();
      run_val = v;
      run_len = pcx_rle_pkg::LEN_W'(1);
      run_on  = 1'b1;
    end
    if (le)
      close_run();
    if (expected_codes.size() > first)
      expected_codes[$].last_of_item = 1'b1;
  endtask

  initial begin
    mismatch_count   = 0;
    pending_codes    = 0;
    pixel_count      = 0;
    code_count       = 0;
    run_val          = '0;
    run_len          = '0;
    run_on           = 1'b0;
    blend_on         = 1'b0;
    leftover_checked = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      run_val  = '0;
      run_len  = '0;
      run_on   = 1'b0;
      blend_on = 1'b0;
      expected_codes.delete();
    end else begin
      if (cfg_we)
        blend_on = cfg_wdata;
      // predict first: a pixel never yields a byte in the cycle it transfers
      if (pixels.valid && pixels.ready) begin
        pixel_count++;
        predict_codes(pixels.pixel_a, pixels.pixel_b, pixels.line_end);
      end
      if (codes.valid && codes.ready) begin
        code_count++;
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", codes.code_byte));
        end else begin
          oldest = expected_codes.pop_front();
          if (codes.code_byte !== oldest.code_byte)
            report_mismatch($sformatf("code_byte %02h, predicted %02h",
                                      codes.code_byte, oldest.code_byte));
          if (codes.last_of_item !== oldest.last_of_item)
            report_mismatch($sformatf("last_of_item %0b, predicted %0b",
                                      codes.last_of_item, oldest.last_of_item));
        end
      end
      if (drained && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_codes.size() != 0)
          report_mismatch($sformatf("%0d predicted bytes never arrived",
                                    expected_codes.size()));
      end
    end
    pending_codes = expected_codes.size();
  end

endmodule
`default_nettype wire

// ===== tb/pcx_rle_line_encoder_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_line_encoder_tb
// Drives pixel streams into the PCX line encoder with random gaps and output
// stalls: a directed set of edge values in both blend settings, then random
// runs, noise and long runs past the run limit. A checker predicts and
// compares every code byte.
// ----------------------------------------------------------------------------
module pcx_rle_line_encoder_tb;

  localparam int unsigned MAX_RUN      = 63;
  localparam int          IDLE_PCT     = 22;
  localparam int          LATENCY_HOLD = 16;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASE_ITEMS  = 105;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic drained;
  logic no_idle;
  logic cur_blend;
  int   mismatch_count;
  int   pending_codes;
  int   pixel_count;
  int   code_count;
  int   cfg_writes;
  int   cycle_count;

  pcx_rle_pix_if  pix_ch ();
  pcx_rle_code_if code_ch ();

  pcx_rle_line_encoder #(
    .MAX_RUN (MAX_RUN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pixels    (pix_ch),
    .codes     (code_ch)
  );

  pcx_rle_code_checker #(
    .MAX_RUN (MAX_RUN)
  ) chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .drained        (drained),
    .pixels         (pix_ch),
    .codes          (code_ch),
    .mismatch_count (mismatch_count),
    .pending_codes  (pending_codes),
    .pixel_count    (pixel_count),
    .code_count     (code_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    code_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic le);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.pixel_a  <= a;
    pix_ch.pixel_b  <= b;
    pix_ch.line_end <= le;
    @(posedge clk);
    while (!pix_ch.ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Pick a pixel pair that encodes to v under the current blend setting.
  task automatic send_value(input logic [7:0] v, input logic le);
    int sum;
    int lo;
    int hi;
    int a;
    if (!cur_blend) begin
      send_pixel(v, 8'($urandom_range(255)), le);
    end else begin
      sum = 2 * int'(v) + $urandom_range(1);
      if (sum > 510)
        sum = 510;
      lo = (sum > 255) ? sum - 255 : 0;
      hi = (sum < 255) ? sum : 255;
      a  = $urandom_range(hi, lo);
      send_pixel(8'(a), 8'(sum - a), le);
    end
  endtask

  task automatic write_blend(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_blend = v;
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted byte, then let the pipe settle.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (pending_codes != 0)
      @(negedge clk);
    repeat (LATENCY_HOLD) @(negedge clk);
  endtask

  task automatic run_random_phase(input int target, input bit open_long);
    int         sent;
    int         kind;
    int         len;
    logic [7:0] val;
    logic [7:0] prev_val;
    logic       le;
    sent     = 0;
    prev_val = 8'h00;
    while (sent < target) begin
      kind = (open_long && sent == 0) ? 15 : $urandom_range(99);
      if (kind < 15) begin
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   $urandom_range(3) == 0);
        sent++;
      end else begin
        if (kind < 20)
          len = (open_long && sent == 0) ? $urandom_range(70, 64) : $urandom_range(70, 60);
        else if (kind < 50)
          len = $urandom_range(12, 2);
        else
          len = $urandom_range(3, 1);
        val = ($urandom_range(99) < 20) ? prev_val : 8'($urandom_range(255));
        for (int i = 0; i < len; i++) begin
          if (i == len - 1)
            le = $urandom_range(99) < 30;
          else
            le = (kind >= 20) && ($urandom_range(99) < 3);
          send_value(val, le);
          sent++;
        end
        prev_val = val;
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    drained         = 1'b0;
    no_idle         = 1'b0;
    cur_blend       = 1'b0;
    cfg_writes      = 0;
    cycle_count     = 0;
    code_ch.ready   = 1'b0;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_a  = 8'h00;
    pix_ch.pixel_b  = 8'h00;
    pix_ch.line_end = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    write_blend(1'b0);
    send_value(8'h00, 1'b1);   // lone low byte stays bare
    send_value(8'hBF, 1'b1);
    send_value(8'hC0, 1'b1);   // lone byte at the mark needs a count
    send_value(8'hFF, 1'b1);
    send_value(8'h05, 1'b0);
    send_value(8'h05, 1'b0);
    send_value(8'h05, 1'b1);
    send_value(8'h07, 1'b0);
    send_value(8'h09, 1'b1);   // broken run and line end in one pixel
    send_value(8'hC5, 1'b0);
    send_value(8'hD0, 1'b1);   // four bytes from one pixel
    send_value(8'h80, 1'b0);
    send_value(8'h80, 1'b0);
    send_value(8'h81, 1'b1);
    settle();

    write_blend(1'b1);
    send_pixel(8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'hFE, 1'b0);
    send_pixel(8'hFE, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'h01, 1'b0);
    send_pixel(8'h01, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'h00, 1'b1);
    send_pixel(8'h80, 8'h7F, 1'b1);
    send_pixel(8'hA5, 8'h5A, 1'b1);
    settle();

    write_blend(1'b0);
    run_random_phase(PHASE_ITEMS, 1'b1);
    settle();
    write_blend(1'b1);
    no_idle = 1'b1;
    run_random_phase(PHASE_ITEMS, 1'b0);
    settle();
    no_idle = 1'b0;
    write_blend(1'b0);
    run_random_phase(PHASE_ITEMS, 1'b0);
    settle();
    write_blend(1'b1);
    run_random_phase(PHASE_ITEMS, 1'b1);
    settle();

    drained <= 1'b1;
    repeat (2) @(negedge clk);
    $display("Run covered %0d pixels and %0d code bytes, %0d blend mode writes",
             pixel_count, code_count, cfg_writes);
    $display("Both blend settings, runs past the length limit, random gaps and stalls");
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
